// ===== sv/hts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants for the humidity and temperature sensor
// sequencer: event and action codes, command words, frame layout, scaling.
// ----------------------------------------------------------------------------
package hts_pkg;

    typedef enum logic [1:0] {
        OP_START_SETUP = 2'd0,
        OP_START_MEAS  = 2'd1,
        OP_WRITE_DONE  = 2'd2,
        OP_READ_DONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_WRITE        = 3'd0,
        ACT_READ         = 3'd1,
        ACT_PUBLISH      = 3'd2,
        ACT_COMM_WARN    = 3'd3,
        ACT_TIMEOUT_WARN = 3'd4,
        ACT_SETUP_FAILED = 3'd5,
        ACT_SETUP_DONE   = 3'd6
    } action_t;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP_WANTED  = 3'd0;
    localparam logic [2:0] REG_HUM_WANTED   = 3'd1;
    localparam logic [2:0] REG_MAX_ATTEMPTS = 3'd2;
    localparam logic [2:0] REG_MEASURE_WAIT = 3'd3;
    localparam logic [2:0] REG_CMD_WAIT     = 3'd4;
    localparam logic [2:0] REG_POWER_WAIT   = 3'd5;
    localparam logic [2:0] REG_STATUS_WAIT  = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int WAIT_W      = 10;
    localparam int RAW_W       = 20;
    localparam int TEMP_W      = 15;
    localparam int HUM_W       = 14;

    // reset values of the configuration registers
    localparam logic       DEF_TEMP_WANTED  = 1'b1;
    localparam logic       DEF_HUM_WANTED   = 1'b1;
    localparam logic [3:0] DEF_MAX_ATTEMPTS = 4'd3;
    localparam logic [7:0] DEF_MEASURE_WAIT = 8'd80;
    localparam logic [9:0] DEF_CMD_WAIT     = 10'd350;
    localparam logic [7:0] DEF_POWER_WAIT   = 8'd40;
    localparam logic [7:0] DEF_STATUS_WAIT  = 8'd5;

    // command words, first byte in the top bits
    localparam logic [23:0] CMD_MODE    = 24'hA80000;
    localparam logic [23:0] CMD_CAL     = 24'hE10800;
    localparam logic [23:0] CMD_MEASURE = 24'hAC3300;

    // status byte checks
    localparam logic [7:0] STATUS_MASK   = 8'h68;
    localparam logic [7:0] STATUS_EXPECT = 8'h08;
    localparam int         BUSY_BIT      = 7;

    localparam logic [2:0] FRAME_BYTES  = 3'd6;
    localparam logic [2:0] STATUS_BYTES = 3'd1;

    // scaling: value = floor(raw * scale / 2^20), temperature offset after
    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;

endpackage
`default_nettype wire

// ===== sv/hts_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hts_scale
// Converts raw 20-bit humidity and temperature readings to hundredths of a
// percent and hundredths of a degree with floor scaling.
// ----------------------------------------------------------------------------
module hts_scale
    import hts_pkg::*;
(
    input  wire logic [RAW_W-1:0]         raw_hum,
    input  wire logic [RAW_W-1:0]         raw_temp,
    output logic      [HUM_W-1:0]         hum_centi,
    output logic signed [TEMP_W-1:0]      temp_centi
);

    localparam int PROD_T_W = RAW_W + TEMP_W;
    localparam int PROD_H_W = RAW_W + HUM_W;

    logic [PROD_T_W-1:0] prod_temp;
    logic [PROD_H_W-1:0] prod_hum;
    logic [TEMP_W-1:0]   temp_unsigned;

    assign prod_temp     = PROD_T_W'(raw_temp) * PROD_T_W'(TEMP_SCALE);
    assign prod_hum      = PROD_H_W'(raw_hum) * PROD_H_W'(HUM_SCALE);
    assign temp_unsigned = prod_temp[PROD_T_W-1:RAW_W];
    assign temp_centi    = $signed(temp_unsigned - TEMP_OFFSET);
    assign hum_centi     = prod_hum[PROD_H_W-1:RAW_W];

endmodule
`default_nettype wire

// ===== sv/humidity_temp_sensor_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_sensor_sequencer
// Host-side sequencer for a humidity and temperature sensor on a two-wire
// bus: takes bus events and returns the next bus action with its wait.
// ----------------------------------------------------------------------------
// Each bus event word is captured in an input register and, once the output
// register is free, resolved into at most one action word, held in an output
// register until taken; the sequencer state updates in that same cycle, so
// one event word is accepted every clock while the output side is not
// stalled. The scaling multipliers sit between the input and output
// registers. Configuration writes take effect at once and are meant for
// when no event is in flight.
module humidity_temp_sensor_sequencer
    import hts_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              opcode,
    input  wire logic                    bus_ok,
    input  wire logic [7:0]              byte0,
    input  wire logic [7:0]              byte1,
    input  wire logic [7:0]              byte2,
    input  wire logic [7:0]              byte3,
    input  wire logic [7:0]              byte4,
    input  wire logic [7:0]              byte5,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [2:0]                   action,
    output logic [WAIT_W-1:0]            wait_ms,
    output logic [23:0]                  command_word,
    output logic [2:0]                   read_count,
    output logic signed [TEMP_W-1:0]     temperature_centi,
    output logic [HUM_W-1:0]             humidity_centi,
    output logic                         temperature_valid,
    output logic                         humidity_valid
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_SET_MODE   = 4'd1,
        PH_SET_CAL    = 4'd2,
        PH_SET_STATUS = 4'd3,
        PH_FAILED     = 4'd4,
        PH_READY      = 4'd5,
        PH_MEAS_CMD   = 4'd6,
        PH_MEAS_READ  = 4'd7,
        PH_MEAS_RECMD = 4'd8
    } phase_t;

    // configuration
    logic       temp_wanted_reg;
    logic       hum_wanted_reg;
    logic [3:0] max_attempts_reg;
    logic [7:0] measure_wait_reg;
    logic [9:0] cmd_wait_reg;
    logic [7:0] power_wait_reg;
    logic [7:0] status_wait_reg;

    // input register
    logic       in_valid_reg;
    opcode_t    opcode_reg;
    logic       bus_ok_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg, b3_reg, b4_reg, b5_reg;

    // sequencer state
    phase_t     phase_reg, phase_next;
    logic [3:0] attempt_reg, attempt_next;

    // output register
    logic                     out_valid_reg;
    action_t                  action_reg;
    logic [WAIT_W-1:0]        wait_reg;
    logic [23:0]              cmd_reg;
    logic [2:0]               count_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [HUM_W-1:0]         hum_reg;
    logic                     temp_valid_reg;
    logic                     hum_valid_reg;

    // resolved word
    logic                     emit;
    action_t                  act_c;
    logic [WAIT_W-1:0]        wait_c;
    logic [23:0]              cmd_c;
    logic [2:0]               count_c;
    logic signed [TEMP_W-1:0] temp_c;
    logic [HUM_W-1:0]         hum_c;
    logic                     temp_valid_c;
    logic                     hum_valid_c;

    logic                     out_free;
    logic                     advance;
    logic [RAW_W-1:0]         raw_hum;
    logic [RAW_W-1:0]         raw_temp;
    logic signed [TEMP_W-1:0] temp_scaled;
    logic [HUM_W-1:0]         hum_scaled;
    logic [3:0]               attempt_inc;
    logic [3:0]               read_cnt;
    logic                     more_reads;
    logic [WAIT_W:0]          status_sum;
    logic [WAIT_W-1:0]        status_wait;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    assign raw_hum  = {b1_reg, b2_reg, b3_reg[7:4]};
    assign raw_temp = {b3_reg[3:0], b4_reg, b5_reg};

    hts_scale u_scale (
        .raw_hum    (raw_hum),
        .raw_temp   (raw_temp),
        .hum_centi  (hum_scaled),
        .temp_centi (temp_scaled)
    );

    assign attempt_inc = attempt_reg + 4'd1;
    assign read_cnt    = (opcode_reg == OP_READ_DONE) ? attempt_inc : attempt_reg;
    assign more_reads  = read_cnt < max_attempts_reg;
    assign status_sum  = (WAIT_W + 1)'(cmd_wait_reg) + (WAIT_W + 1)'(status_wait_reg);
    assign status_wait = status_sum[WAIT_W] ? {WAIT_W{1'b1}} : status_sum[WAIT_W-1:0];

    always_comb
    begin
        emit         = 1'b0;
        act_c        = ACT_WRITE;
        wait_c       = '0;
        cmd_c        = '0;
        count_c      = '0;
        temp_c       = '0;
        hum_c        = '0;
        temp_valid_c = 1'b0;
        hum_valid_c  = 1'b0;
        phase_next   = phase_reg;
        attempt_next = attempt_reg;
        unique case (opcode_reg)
            OP_START_SETUP:
            begin
                emit         = 1'b1;
                phase_next   = PH_SET_MODE;
                attempt_next = '0;
                wait_c       = WAIT_W'(power_wait_reg);
                cmd_c        = CMD_MODE;
            end
            OP_START_MEAS:
            begin
                if (phase_reg == PH_READY)
                begin
                    emit         = 1'b1;
                    phase_next   = PH_MEAS_CMD;
                    attempt_next = '0;
                    cmd_c        = CMD_MEASURE;
                end
            end
            OP_WRITE_DONE:
            begin
                unique case (phase_reg)
                    PH_SET_MODE:
                    begin
                        emit   = 1'b1;
                        wait_c = cmd_wait_reg;
                        if (!bus_ok_reg)
                        begin
                            phase_next = PH_FAILED;
                            act_c      = ACT_SETUP_FAILED;
                        end
                        else
                        begin
                            phase_next = PH_SET_CAL;
                            cmd_c      = CMD_CAL;
                        end
                    end
                    PH_SET_CAL:
                    begin
                        emit = 1'b1;
                        if (!bus_ok_reg)
                        begin
                            phase_next = PH_FAILED;
                            act_c      = ACT_SETUP_FAILED;
                            wait_c     = cmd_wait_reg;
                        end
                        else
                        begin
                            phase_next = PH_SET_STATUS;
                            act_c      = ACT_READ;
                            wait_c     = status_wait;
                            count_c    = STATUS_BYTES;
                        end
                    end
                    PH_MEAS_CMD, PH_MEAS_RECMD:
                    begin
                        emit = 1'b1;
                        if (!bus_ok_reg)
                        begin
                            phase_next = PH_READY;
                            act_c      = ACT_COMM_WARN;
                        end
                        else if (more_reads)
                        begin
                            phase_next = PH_MEAS_READ;
                            act_c      = ACT_READ;
                            wait_c     = WAIT_W'(measure_wait_reg);
                            count_c    = FRAME_BYTES;
                        end
                        else
                        begin
                            phase_next = PH_READY;
                            act_c      = ACT_TIMEOUT_WARN;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
            OP_READ_DONE:
            begin
                if (phase_reg == PH_SET_STATUS)
                begin
                    emit = 1'b1;
                    if (!bus_ok_reg || (b0_reg & STATUS_MASK) != STATUS_EXPECT)
                    begin
                        phase_next = PH_FAILED;
                        act_c      = ACT_SETUP_FAILED;
                    end
                    else
                    begin
                        phase_next = PH_READY;
                        act_c      = ACT_SETUP_DONE;
                    end
                end
                else if (phase_reg == PH_MEAS_READ)
                begin
                    emit         = 1'b1;
                    attempt_next = attempt_inc;
                    if (!bus_ok_reg || b0_reg[BUSY_BIT])
                    begin
                        if (more_reads)
                        begin
                            act_c   = ACT_READ;
                            wait_c  = WAIT_W'(measure_wait_reg);
                            count_c = FRAME_BYTES;
                        end
                        else
                        begin
                            phase_next = PH_READY;
                            act_c      = ACT_TIMEOUT_WARN;
                        end
                    end
                    else if (raw_hum == '0 && hum_wanted_reg)
                    begin
                        phase_next = PH_MEAS_RECMD;
                        cmd_c      = CMD_MEASURE;
                    end
                    else
                    begin
                        phase_next   = PH_READY;
                        act_c        = ACT_PUBLISH;
                        temp_valid_c = temp_wanted_reg;
                        hum_valid_c  = hum_wanted_reg && raw_hum != '0;
                        temp_c       = temp_wanted_reg ? temp_scaled : '0;
                        hum_c        = (hum_wanted_reg && raw_hum != '0) ? hum_scaled : '0;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_wanted_reg  <= DEF_TEMP_WANTED;
            hum_wanted_reg   <= DEF_HUM_WANTED;
            max_attempts_reg <= DEF_MAX_ATTEMPTS;
            measure_wait_reg <= DEF_MEASURE_WAIT;
            cmd_wait_reg     <= DEF_CMD_WAIT;
            power_wait_reg   <= DEF_POWER_WAIT;
            status_wait_reg  <= DEF_STATUS_WAIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TEMP_WANTED:  temp_wanted_reg  <= cfg_data[0];
                REG_HUM_WANTED:   hum_wanted_reg   <= cfg_data[0];
                REG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[3:0];
                REG_MEASURE_WAIT: measure_wait_reg <= cfg_data[7:0];
                REG_CMD_WAIT:     cmd_wait_reg     <= cfg_data[9:0];
                REG_POWER_WAIT:   power_wait_reg   <= cfg_data[7:0];
                REG_STATUS_WAIT:  status_wait_reg  <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            opcode_reg <= opcode_t'(opcode);
            bus_ok_reg <= bus_ok;
            b0_reg     <= byte0;
            b1_reg     <= byte1;
            b2_reg     <= byte2;
            b3_reg     <= byte3;
            b4_reg     <= byte4;
            b5_reg     <= byte5;
        end
    end

    // sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            attempt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg   <= phase_next;
                attempt_reg <= attempt_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && emit;
            end
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            action_reg     <= act_c;
            wait_reg       <= wait_c;
            cmd_reg        <= cmd_c;
            count_reg      <= count_c;
            temp_reg       <= temp_c;
            hum_reg        <= hum_c;
            temp_valid_reg <= temp_valid_c;
            hum_valid_reg  <= hum_valid_c;
        end
    end

    assign out_valid         = out_valid_reg;
    assign action            = action_reg;
    assign wait_ms           = wait_reg;
    assign command_word      = cmd_reg;
    assign read_count        = count_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;
    assign temperature_valid = temp_valid_reg;
    assign humidity_valid    = hum_valid_reg;

`ifndef ASSERT_OFF
    a_publish_ready: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && act_c == ACT_PUBLISH |=> phase_reg == PH_READY)
        else $error("publish did not return to ready");

    a_cmd_only_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_WRITE |-> command_word == '0)
        else $error("command word set on a non-write action");

    a_valid_only_publish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_PUBLISH |-> !temperature_valid && !humidity_valid)
        else $error("value valid on a non-publish action");

    a_count_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_READ |-> read_count == '0)
        else $error("read count set on a non-read action");
`endif

endmodule
`default_nettype wire
